[sv/csh_pkg.sv]
// Shared types and constants for the channel statistics and histogram block.
// No dependencies; imported by csh_div and the top level.
package csh_pkg;

    localparam int MAX_CHANNELS = 4096;
    localparam int CH_AW        = $clog2(MAX_CHANNELS);
    localparam int HIST_BINS    = 256;
    localparam int HIST_AW      = $clog2(HIST_BINS);
    localparam int SUM_BITS     = 48;
    localparam int ACC_BITS     = 40;
    localparam int MEAN_BITS    = 16;
    localparam int CNT_BITS     = 32;
    localparam int SAMP_BITS    = 8;
    localparam int IDX_BITS     = 12;
    localparam int CFG_W        = 13;
    localparam int DIVD_BITS    = ACC_BITS + 8;

    localparam logic [CFG_W-1:0] ROWLEN_RESET = CFG_W'(1024);

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_END_SUB = 2'd1,
        OP_RD_CHAN = 2'd2,
        OP_RD_HIST = 2'd3
    } t_op;

    // one entry of the channel memory
    typedef struct packed {
        logic [MEAN_BITS-1:0] mean;
        logic [ACC_BITS-1:0]  acc;
        logic [SAMP_BITS-1:0] maxv;
        logic [SAMP_BITS-1:0] minv;
        logic [SUM_BITS-1:0]  total;
    } t_chan_word;

    localparam int CHAN_W = $bits(t_chan_word);

    // result item as packed on the output tdata
    typedef struct packed {
        logic                 index_error;
        logic [CNT_BITS-1:0]  bin_count;
        logic [CNT_BITS-1:0]  total_rows;
        logic [MEAN_BITS-1:0] subint_mean;
        logic [SAMP_BITS-1:0] max_value;
        logic [SAMP_BITS-1:0] min_value;
        logic [SUM_BITS-1:0]  total_sum;
    } t_result;

    localparam int RES_W  = $bits(t_result);
    localparam int OUT_TW = ((RES_W + 7) / 8) * 8;
    localparam int IN_TW  = ((SAMP_BITS + IDX_BITS + 7) / 8) * 8;

endpackage

[sv/csh_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module csh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/csh_div.sv]
// Restoring divider, one quotient bit per cycle, for the subint mean.
// Depends on csh_pkg.
module csh_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [csh_pkg::DIVD_BITS-1:0] i_dividend,
    input  logic [csh_pkg::CNT_BITS-1:0]  i_divisor,
    output logic                          o_done,
    output logic [csh_pkg::DIVD_BITS-1:0] o_quotient
);
    import csh_pkg::*;

    localparam int CW = $clog2(DIVD_BITS + 1);

    logic [CNT_BITS-1:0]  r_rem, n_rem;
    logic [CNT_BITS-1:0]  r_dvs;
    logic [DIVD_BITS-1:0] r_q, n_q;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy, r_done;
    logic [CNT_BITS:0]    trial;
    logic                 fits;

    always_comb begin
        trial = {r_rem, r_q[DIVD_BITS-1]};
        fits  = trial >= {1'b0, r_dvs};
        n_rem = fits ? CNT_BITS'(trial - {1'b0, r_dvs}) : trial[CNT_BITS-1:0];
        n_q   = {r_q[DIVD_BITS-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIVD_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider restarted while busy");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0) else $error("divider count underflow");
endmodule

[sv/channel_stats_histogram.sv]
// Top level: per-channel running statistics and sample histogram.
// Depends on csh_pkg, csh_ram, csh_div.
//
//  channel  | direction | contents
//  s_axis   | in        | tuser: op[1:0]; tdata: sample[7:0], index[19:8]
//  m_axis   | out       | tdata: total_sum, min, max, subint_mean, total_rows,
//           |           |        bin_count, index_error (lowest bit first)
//  cfg      | in        | i_cfg_we / i_cfg_wdata: num_channels
//
// Sample and read items each pass a channel memory read, then a write back or
// result load. End of subint walks all 4096 channel entries, each bound by the
// bit-serial divider. After reset a clearing pass zeroes both memories; no item
// is taken meanwhile. A waiting result in the output register does not stall
// sample items; a read item waits in S_READ until the register frees.
module channel_stats_histogram (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [csh_pkg::IN_TW-1:0]    s_axis_tdata,   // sample, index, zero pad
    input  logic [1:0]                   s_axis_tuser,   // op
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [csh_pkg::OUT_TW-1:0]   m_axis_tdata,   // total_sum, min_value,
                                                         // max_value, subint_mean,
                                                         // total_rows, bin_count,
                                                         // index_error, zero pad
    input  logic                         i_cfg_we,
    input  logic [csh_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import csh_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_SAMP   = 7'b0000100,
        S_READ   = 7'b0001000,
        S_SUB_RD = 7'b0010000,
        S_SUB_DV = 7'b0100000,
        S_SUB_WR = 7'b1000000
    } t_state;

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_rowlen;
    logic [CH_AW-1:0]     r_pos, r_ch, r_walk;
    logic [CNT_BITS-1:0]  r_rows_all, r_rows_sub;
    logic                 r_first;
    logic [SAMP_BITS-1:0] r_sample;
    logic [IDX_BITS-1:0]  r_index;
    t_op                  r_op;
    logic                 r_mv;
    t_result              r_res;
    t_chan_word           r_word;

    t_op                  in_op;
    logic [SAMP_BITS-1:0] in_sample;
    logic [IDX_BITS-1:0]  in_index;
    logic                 accept;
    logic [CH_AW-1:0]     ch_eff;

    logic                 chan_we, hist_we;
    logic [CH_AW-1:0]     chan_waddr, chan_raddr;
    logic [HIST_AW-1:0]   hist_waddr, hist_raddr;
    t_chan_word           chan_wdata, chan_rdata, samp_word;
    logic [CNT_BITS-1:0]  hist_wdata, hist_rdata;
    logic [SUM_BITS:0]    tot_sum;
    logic [ACC_BITS:0]    acc_sum;
    logic [CFG_W-1:0]     ch_next;
    logic                 row_done;
    logic                 div_done;
    logic [DIVD_BITS-1:0] quot;
    logic [MEAN_BITS-1:0] mean;
    t_result              res;
    logic                 out_free;

    assign in_op     = t_op'(s_axis_tuser);
    assign in_sample = s_axis_tdata[SAMP_BITS-1:0];
    assign in_index  = s_axis_tdata[SAMP_BITS+IDX_BITS-1:SAMP_BITS];
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free  = !r_mv || m_axis_tready;
    // a position left beyond a shrunk row starts a new row
    assign ch_eff    = ({1'b0, r_pos} >= r_rowlen) ? '0 : r_pos;

    // sample update of one channel entry
    always_comb begin
        samp_word = chan_rdata;
        tot_sum = {1'b0, chan_rdata.total} + (SUM_BITS+1)'(r_sample);
        acc_sum = {1'b0, chan_rdata.acc} + (ACC_BITS+1)'(r_sample);
        samp_word.total = tot_sum[SUM_BITS] ? '1 : tot_sum[SUM_BITS-1:0];
        samp_word.acc   = acc_sum[ACC_BITS] ? '1 : acc_sum[ACC_BITS-1:0];
        if (r_first || r_sample < chan_rdata.minv) begin
            samp_word.minv = r_sample;
        end
        if (r_first || r_sample > chan_rdata.maxv) begin
            samp_word.maxv = r_sample;
        end
        ch_next  = CFG_W'(r_ch) + 1'b1;
        row_done = ch_next >= r_rowlen;
    end

    always_comb begin
        mean = '0;
        if (r_rows_sub != '0) begin
            mean = (quot[DIVD_BITS-1:MEAN_BITS] != '0) ? '1 : quot[MEAN_BITS-1:0];
        end
    end

    // memory port selection
    always_comb begin
        chan_we    = 1'b0;
        hist_we    = 1'b0;
        chan_waddr = r_ch;
        chan_wdata = samp_word;
        hist_waddr = HIST_AW'(r_sample);
        hist_wdata = (hist_rdata == '1) ? hist_rdata : hist_rdata + 1'b1;
        chan_raddr = (in_op == OP_SAMPLE) ? ch_eff : in_index[CH_AW-1:0];
        hist_raddr = (in_op == OP_SAMPLE) ? HIST_AW'(in_sample) : in_index[HIST_AW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                chan_we    = 1'b1;
                hist_we    = 1'b1;
                chan_waddr = r_walk;
                chan_wdata = '0;
                hist_waddr = r_walk[HIST_AW-1:0];
                hist_wdata = '0;
            end
            S_SAMP: begin
                chan_we = 1'b1;
                hist_we = 1'b1;
            end
            // keep the read data steady while the result waits
            S_READ: begin
                chan_raddr = r_index[CH_AW-1:0];
                hist_raddr = r_index[HIST_AW-1:0];
            end
            S_SUB_RD: begin
                chan_raddr = r_walk;
            end
            S_SUB_WR: begin
                chan_we    = 1'b1;
                chan_waddr = r_walk;
                chan_wdata = r_word;
                chan_wdata.acc  = '0;
                chan_wdata.mean = mean;
            end
            default: ;
        endcase
    end

    // result assembly
    always_comb begin
        res = '0;
        res.total_rows = r_rows_all;
        if (r_op == OP_RD_CHAN) begin
            if ({1'b0, r_index} >= r_rowlen) begin
                res.index_error = 1'b1;
            end else begin
                res.total_sum   = chan_rdata.total;
                res.min_value   = chan_rdata.minv;
                res.max_value   = chan_rdata.maxv;
                res.subint_mean = chan_rdata.mean;
            end
        end else begin
            if (32'(r_index) >= HIST_BINS) begin
                res.index_error = 1'b1;
            end else begin
                res.bin_count = hist_rdata;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_walk == CH_AW'(MAX_CHANNELS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        OP_SAMPLE:  n_state = S_SAMP;
                        OP_END_SUB: n_state = S_SUB_RD;
                        OP_RD_CHAN,
                        OP_RD_HIST: n_state = S_READ;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_SAMP: n_state = S_IDLE;
            S_READ: begin
                if (out_free) n_state = S_IDLE;
            end
            S_SUB_RD: n_state = S_SUB_DV;
            S_SUB_DV: begin
                if (div_done) n_state = S_SUB_WR;
            end
            S_SUB_WR: begin
                n_state = (r_walk == CH_AW'(MAX_CHANNELS - 1)) ? S_IDLE : S_SUB_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    logic r_div_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_rowlen   <= ROWLEN_RESET;
            r_pos      <= '0;
            r_walk     <= '0;
            r_rows_all <= '0;
            r_rows_sub <= '0;
            r_first    <= 1'b1;
            r_mv       <= 1'b0;
            r_div_go   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= (r_state == S_SUB_RD);
            if (i_cfg_we) begin
                if (i_cfg_wdata == '0) begin
                    r_rowlen <= CFG_W'(1);
                end else if (i_cfg_wdata > CFG_W'(MAX_CHANNELS)) begin
                    r_rowlen <= CFG_W'(MAX_CHANNELS);
                end else begin
                    r_rowlen <= i_cfg_wdata;
                end
            end
            if (r_state == S_READ && out_free) r_mv <= 1'b1;
            else if (m_axis_tready) r_mv <= 1'b0;
            unique case (r_state)
                S_CLEAR: r_walk <= r_walk + 1'b1;
                S_SAMP: begin
                    if (row_done) begin
                        r_pos   <= '0;
                        r_first <= 1'b0;
                        if (r_rows_all != '1) r_rows_all <= r_rows_all + 1'b1;
                        if (r_rows_sub != '1) r_rows_sub <= r_rows_sub + 1'b1;
                    end else begin
                        r_pos <= ch_next[CH_AW-1:0];
                    end
                end
                S_SUB_WR: begin
                    r_walk <= r_walk + 1'b1;
                    if (r_walk == CH_AW'(MAX_CHANNELS - 1)) r_rows_sub <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= in_op;
            r_sample <= in_sample;
            r_index  <= in_index;
            r_ch     <= ch_eff;
        end
        if (r_state == S_READ && out_free) r_res <= res;
        // read data lands in S_SUB_DV's first cycle; it is held in r_word
        if (r_div_go) r_word <= chan_rdata;
    end

    csh_ram #(.WIDTH(CHAN_W), .DEPTH(MAX_CHANNELS)) u_chan_ram (
        .i_clk  (i_clk),
        .i_we   (chan_we),
        .i_waddr(chan_waddr),
        .i_wdata(chan_wdata),
        .i_raddr(chan_raddr),
        .o_rdata(chan_rdata)
    );

    csh_ram #(.WIDTH(CNT_BITS), .DEPTH(HIST_BINS)) u_hist_ram (
        .i_clk  (i_clk),
        .i_we   (hist_we),
        .i_waddr(hist_waddr),
        .i_wdata(hist_wdata),
        .i_raddr(hist_raddr),
        .o_rdata(hist_rdata)
    );

    csh_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_go),
        .i_dividend({chan_rdata.acc, 8'd0}),
        .i_divisor (r_rows_sub),
        .o_done    (div_done),
        .o_quotient(quot)
    );

    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = OUT_TW'(r_res);

    a_rows_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows_sub <= r_rows_all) else $error("subint rows exceed total rows");
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_mv) |-> $past(r_state == S_READ)) else $error("result from wrong state");
    a_no_idle_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !chan_we && !hist_we) else $error("memory write while idle");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_SUB_DV) else $error("stray divider completion");
endmodule
